// ===== sv/ogfs_pkg.sv =====
// Shared types, constants and helpers for the occupancy grid free cell search core.
package ogfs_pkg;

  localparam int GRID_SIDE  = 256;
  localparam int COORD_BITS = 24;
  localparam int CELL_W     = $clog2(GRID_SIDE);
  localparam int ADDR_W     = 2 * CELL_W;
  localparam int DEPTH      = GRID_SIDE * GRID_SIDE;
  localparam int SIZE_W     = CELL_W + 1;
  localparam int HGT_W      = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SCALE_W    = 24;
  localparam int SCALE_LO_W = 12;
  localparam int HALF_W     = 5;
  localparam int REACH_W    = 8;
  localparam int OUT_CELL_W = 8;
  localparam int NDIR       = 8;
  localparam int DIR_W      = 3;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MUL_W      = DIFF_W + SCALE_LO_W + 1;
  localparam int PROD_W     = DIFF_W + SCALE_W + 1;
  localparam int Q_W        = PROD_W - COORD_BITS;
  localparam int SQ_W       = Q_W + 1;
  localparam int POS_W      = CELL_W + 2;

  localparam logic signed [HGT_W-1:0] HGT_MIN = {1'b1, {(HGT_W-1){1'b0}}};
  localparam logic signed [HGT_W-1:0] HGT_MAX = {1'b0, {(HGT_W-1){1'b1}}};

  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PT_OFF = 2'd1,
    ST_Q_OFF  = 2'd2,
    ST_NO_DIR = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Z  = 3'd1,
    CFG_SCALE     = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_HEIGHT    = 3'd4,
    CFG_HALF      = 3'd5,
    CFG_REACH     = 3'd6,
    CFG_LIMIT     = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_DISP, S_CLR,
    S_INS_RD, S_INS_WR, S_SQ, S_Q_RD, S_Q_CHK, S_WALK, S_WALK_END,
    S_PICK, S_PRES, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_ZERO, RES_INS, RES_QOFF, RES_QFREE, RES_PICK
  } res_sel_t;

  typedef struct packed {
    logic     in_take;
    logic     clr_wr;
    logic     mul_en;
    logic     mul_hi;
    logic     mul_z;
    logic     ins_rd;
    logic     ins_wr;
    logic     sq_wr;
    logic     q_rd;
    logic     walk_init;
    logic     walk_issue;
    logic     pick;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  on_grid;
    logic  clr_last;
    logic  sq_empty;
    logic  sq_last;
    logic  occ_free;
    logic  reach_zero;
    logic  walk_last;
    logic  pick_last;
    logic  out_free;
  } sts_t;

  function automatic logic [1:0] dir_row(input logic [DIR_W-1:0] d);
    case (d)
      3'd1, 3'd2, 3'd3: dir_row = DIR_POS;
      3'd5, 3'd6, 3'd7: dir_row = DIR_NEG;
      default:          dir_row = DIR_ZERO;
    endcase
  endfunction

  function automatic logic [1:0] dir_col(input logic [DIR_W-1:0] d);
    case (d)
      3'd0, 3'd1, 3'd7: dir_col = DIR_POS;
      3'd3, 3'd4, 3'd5: dir_col = DIR_NEG;
      default:          dir_col = DIR_ZERO;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] step_pos(input logic [CELL_W-1:0] base,
                                                       input logic [REACH_W-1:0] s,
                                                       input logic [1:0] dir);
    logic signed [POS_W-1:0] b;
    logic signed [POS_W-1:0] st;
    b  = signed'({2'b00, base});
    st = signed'({{(POS_W-REACH_W){1'b0}}, s});
    case (dir)
      DIR_POS: step_pos = b + st;
      DIR_NEG: step_pos = b - st;
      default: step_pos = b;
    endcase
  endfunction

endpackage

// ===== sv/occupancy_grid_free_cell_search_core.sv =====
// Top level of the occupancy grid free cell search core.
//
//   port group  direction  handshake        word
//   in_*        input      valid / ready    kind, px, py, pz
//   out_*       output     valid / ready    cell_col, cell_row, found, status
//   cfg_*       input      write enable     register index, write data
//
// One word at a time. Each word passes accept, the split multiply (x then z,
// low then high scale half), dispatch and hand-off. Insert: a read and a write
// state, then one inflated cell written per cycle (up to 4*half^2 cells).
// Query: a read and a check state; on an occupied cell a walk with one map read
// per direction step out to search_reach, an end state, a pick and a result state.
// Clear, and reset, sweep both maps one cell a cycle, all 65536 cells.
// A stalled result sits in the output register; the next word is taken and
// worked, then waits in its hand-off state until that register frees.
module occupancy_grid_free_cell_search_core import ogfs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic signed [COORD_BITS-1:0]  in_px,
  input  logic signed [COORD_BITS-1:0]  in_py,
  input  logic signed [COORD_BITS-1:0]  in_pz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_CELL_W-1:0]         out_cell_col,
  output logic [OUT_CELL_W-1:0]         out_cell_row,
  output logic                          out_found,
  output logic [1:0]                    out_status,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  ogfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ogfs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_kind),
    .in_px        (in_px),
    .in_py        (in_py),
    .in_pz        (in_pz),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cell_col (out_cell_col),
    .out_cell_row (out_cell_row),
    .out_found    (out_found),
    .out_status   (out_status)
  );

endmodule

// ===== sv/ogfs_ram.sv =====
// Generic single write port RAM with registered read.
module ogfs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ogfs_ctrl.sv =====
// Sequencer for the occupancy grid core: state machine issuing datapath commands.
module ogfs_ctrl import ogfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_MUL0;
      S_MUL0:   state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_MUL3;
      S_MUL3:   state_nxt = S_DISP;
      S_DISP: begin
        case (sts.kind)
          KIND_INSERT: state_nxt = S_INS_RD;
          KIND_QUERY:  state_nxt = sts.on_grid ? S_Q_RD : S_DONE;
          KIND_CLEAR:  state_nxt = S_CLR;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_CLR:    if (sts.clr_last) state_nxt = S_DONE;
      S_INS_RD: state_nxt = S_INS_WR;
      S_INS_WR: state_nxt = sts.sq_empty ? S_DONE : S_SQ;
      S_SQ:     if (sts.sq_last) state_nxt = S_DONE;
      S_Q_RD:   state_nxt = S_Q_CHK;
      S_Q_CHK: begin
        if (sts.occ_free) begin
          state_nxt = S_DONE;
        end else if (sts.reach_zero) begin
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK:     if (sts.walk_last) state_nxt = S_WALK_END;
      S_WALK_END: state_nxt = S_PICK;
      S_PICK:     if (sts.pick_last) state_nxt = S_PRES;
      S_PRES:     state_nxt = S_DONE;
      S_DONE:     if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_INIT: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.in_take  = in_valid;
        cmd.res_load = in_valid;
        cmd.res_sel  = RES_ZERO;
      end
      S_MUL0: cmd.mul_en = 1'b1;
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_z  = 1'b1;
      end
      S_MUL3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        cmd.mul_z  = 1'b1;
      end
      S_DISP: begin
        if (sts.kind == KIND_QUERY && !sts.on_grid) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_QOFF;
        end
      end
      S_CLR: cmd.clr_wr = 1'b1;
      S_INS_RD: begin
        cmd.ins_rd   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_INS;
      end
      S_INS_WR: cmd.ins_wr = 1'b1;
      S_SQ:     cmd.sq_wr  = 1'b1;
      S_Q_RD:   cmd.q_rd   = 1'b1;
      S_Q_CHK: begin
        if (sts.occ_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_QFREE;
        end else begin
          cmd.walk_init = 1'b1;
        end
      end
      S_WALK: cmd.walk_issue = 1'b1;
      S_PICK: cmd.pick = 1'b1;
      S_PRES: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_PICK;
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/ogfs_dp.sv =====
// Datapath: config registers, quantizer, grid memories, direction walk and result registers.
module ogfs_dp import ogfs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmd_t                           cmd,
  output sts_t                           sts,
  input  logic [1:0]                     in_kind,
  input  logic signed [COORD_BITS-1:0]   in_px,
  input  logic signed [COORD_BITS-1:0]   in_py,
  input  logic signed [COORD_BITS-1:0]   in_pz,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [OUT_CELL_W-1:0]          out_cell_col,
  output logic [OUT_CELL_W-1:0]          out_cell_row,
  output logic                           out_found,
  output logic [1:0]                     out_status
);

  // configuration
  logic signed [COORD_BITS-1:0] origin_x_r, origin_z_r;
  logic [SCALE_W-1:0]           scale_r;
  logic [SIZE_W-1:0]            width_r, height_r;
  logic [HALF_W-1:0]            half_r;
  logic [REACH_W-1:0]           reach_r;
  logic signed [HGT_W-1:0]      limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_z_r <= '0;
      scale_r    <= SCALE_W'(163840);
      width_r    <= SIZE_W'(256);
      height_r   <= SIZE_W'(256);
      half_r     <= HALF_W'(9);
      reach_r    <= REACH_W'(80);
      limit_r    <= HGT_W'(2458);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: origin_x_r <= signed'(cfg_wdata[COORD_BITS-1:0]);
        CFG_ORIGIN_Z: origin_z_r <= signed'(cfg_wdata[COORD_BITS-1:0]);
        CFG_SCALE:    scale_r    <= cfg_wdata[SCALE_W-1:0];
        CFG_WIDTH:    width_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT:   height_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_HALF:     half_r     <= cfg_wdata[HALF_W-1:0];
        CFG_REACH:    reach_r    <= cfg_wdata[REACH_W-1:0];
        CFG_LIMIT:    limit_r    <= signed'(cfg_wdata[HGT_W-1:0]);
        default:      ;
      endcase
    end
  end

  logic [SIZE_W-1:0] eff_w, eff_h;
  assign eff_w = (width_r  > SIZE_W'(GRID_SIDE)) ? SIZE_W'(GRID_SIDE) : width_r;
  assign eff_h = (height_r > SIZE_W'(GRID_SIDE)) ? SIZE_W'(GRID_SIDE) : height_r;

  // input word
  kind_t                        kind_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      kind_r <= kind_t'(in_kind);
      px_r   <= in_px;
      py_r   <= in_py;
      pz_r   <= in_pz;
    end
  end

  // quantizer: 25 x 24 product in two 12-bit halves of the scale
  logic signed [DIFF_W-1:0]       diff;
  logic signed [SCALE_LO_W:0]     mul_b;
  logic signed [MUL_W-1:0]        prod;
  logic signed [PROD_W-1:0]       prod_ext, sum;
  logic signed [PROD_W-1:0]       acc_r;
  logic signed [Q_W-1:0]          c_r, r_r;

  assign diff = cmd.mul_z ? (signed'({pz_r[COORD_BITS-1], pz_r}) -
                             signed'({origin_z_r[COORD_BITS-1], origin_z_r}))
                          : (signed'({px_r[COORD_BITS-1], px_r}) -
                             signed'({origin_x_r[COORD_BITS-1], origin_x_r}));
  assign mul_b = signed'({1'b0, cmd.mul_hi ? scale_r[SCALE_W-1:SCALE_LO_W]
                                            : scale_r[SCALE_LO_W-1:0]});
  assign prod     = diff * mul_b;
  assign prod_ext = {{(PROD_W-MUL_W){prod[MUL_W-1]}}, prod};
  assign sum      = cmd.mul_hi ? (acc_r + (prod_ext <<< SCALE_LO_W)) : prod_ext;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      acc_r <= sum;
      if (cmd.mul_hi) begin
        if (cmd.mul_z) begin
          r_r <= sum[PROD_W-1:COORD_BITS];
        end else begin
          c_r <= sum[PROD_W-1:COORD_BITS];
        end
      end
    end
  end

  logic on_grid;
  assign on_grid = !c_r[Q_W-1] && !r_r[Q_W-1] &&
                   (c_r < signed'({{(Q_W-SIZE_W){1'b0}}, eff_w})) &&
                   (r_r < signed'({{(Q_W-SIZE_W){1'b0}}, eff_h}));

  logic [ADDR_W-1:0] cell_addr;
  assign cell_addr = {r_r[CELL_W-1:0], c_r[CELL_W-1:0]};

  // memories
  logic [ADDR_W-1:0]       clr_r;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    occ_we, hgt_we;
  logic [ADDR_W-1:0]       occ_waddr, hgt_waddr;
  logic [0:0]              occ_wdata, occ_rd;
  logic [HGT_W-1:0]        hgt_wdata, hgt_rd_raw;
  logic signed [HGT_W-1:0] h_rd, hsat;
  logic [CELL_W-1:0]       sqi_r, sqj_r;

  assign h_rd = signed'(hgt_rd_raw);
  assign hsat = (py_r == HGT_MIN) ? HGT_MAX : -py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + ADDR_W'(1);
    end
  end

  assign occ_we    = cmd.clr_wr | cmd.sq_wr;
  assign occ_waddr = cmd.clr_wr ? clr_r : {sqj_r, sqi_r};
  assign occ_wdata = cmd.sq_wr ? 1'b1 : 1'b0;
  assign hgt_we    = cmd.clr_wr | (cmd.ins_wr && on_grid && (h_rd < hsat));
  assign hgt_waddr = cmd.clr_wr ? clr_r : cell_addr;
  assign hgt_wdata = cmd.clr_wr ? HGT_MIN : hsat;

  ogfs_ram #(.W(1), .DEPTH(DEPTH)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (rd_addr),
    .rdata (occ_rd)
  );

  ogfs_ram #(.W(HGT_W), .DEPTH(DEPTH)) u_hgt (
    .clk   (clk),
    .we    (hgt_we),
    .waddr (hgt_waddr),
    .wdata (hgt_wdata),
    .raddr (rd_addr),
    .rdata (hgt_rd_raw)
  );

  // inflated square bounds, clipped to the grid
  logic signed [SQ_W-1:0] one_sq, half_ext, w_m1, h_m1;
  logic signed [SQ_W-1:0] c_lo, c_hi, r_lo, r_hi, c0, c1, r0, r1;
  logic [CELL_W-1:0]      sq_c0_r, sq_c1_r, sq_r0_r, sq_r1_r;
  logic                   sq_empty_r;

  assign one_sq   = {{(SQ_W-1){1'b0}}, 1'b1};
  assign half_ext = signed'({{(SQ_W-HALF_W){1'b0}}, half_r});
  assign w_m1     = signed'({{(SQ_W-SIZE_W){1'b0}}, eff_w}) - one_sq;
  assign h_m1     = signed'({{(SQ_W-SIZE_W){1'b0}}, eff_h}) - one_sq;
  assign c_lo     = signed'({c_r[Q_W-1], c_r}) - half_ext;
  assign c_hi     = signed'({c_r[Q_W-1], c_r}) + half_ext - one_sq;
  assign r_lo     = signed'({r_r[Q_W-1], r_r}) - half_ext;
  assign r_hi     = signed'({r_r[Q_W-1], r_r}) + half_ext - one_sq;
  assign c0       = c_lo[SQ_W-1] ? '0 : c_lo;
  assign r0       = r_lo[SQ_W-1] ? '0 : r_lo;
  assign c1       = (c_hi > w_m1) ? w_m1 : c_hi;
  assign r1       = (r_hi > h_m1) ? h_m1 : r_hi;

  always_ff @(posedge clk) begin
    if (cmd.ins_rd) begin
      sq_c0_r    <= c0[CELL_W-1:0];
      sq_c1_r    <= c1[CELL_W-1:0];
      sq_r0_r    <= r0[CELL_W-1:0];
      sq_r1_r    <= r1[CELL_W-1:0];
      sq_empty_r <= (c0 > c1) || (r0 > r1);
    end
    if (cmd.ins_wr) begin
      sqi_r <= sq_c0_r;
      sqj_r <= sq_r0_r;
    end else if (cmd.sq_wr) begin
      if (sqi_r == sq_c1_r) begin
        sqi_r <= sq_c0_r;
        sqj_r <= sqj_r + CELL_W'(1);
      end else begin
        sqi_r <= sqi_r + CELL_W'(1);
      end
    end
  end

  // direction walk: issue one (step, direction) per cycle, evaluate it the next
  logic [REACH_W-1:0]      step_r;
  logic [DIR_W-1:0]        wd_r;
  logic signed [POS_W-1:0] wy, wx;
  logic                    won;
  logic                    ev_v_r, ev_on_r;
  logic [DIR_W-1:0]        ev_d_r;
  logic [CELL_W-1:0]       ev_x_r, ev_y_r;

  assign wy  = step_pos(r_r[CELL_W-1:0], step_r, dir_row(wd_r));
  assign wx  = step_pos(c_r[CELL_W-1:0], step_r, dir_col(wd_r));
  assign won = !wy[POS_W-1] && !wx[POS_W-1] &&
               (wy < signed'({{(POS_W-SIZE_W){1'b0}}, eff_h})) &&
               (wx < signed'({{(POS_W-SIZE_W){1'b0}}, eff_w}));

  assign rd_addr = cmd.walk_issue ? {wy[CELL_W-1:0], wx[CELL_W-1:0]} : cell_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r <= 1'b0;
    end else begin
      ev_v_r <= cmd.walk_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      step_r <= REACH_W'(1);
      wd_r   <= '0;
    end else if (cmd.walk_issue) begin
      wd_r <= wd_r + DIR_W'(1);
      if (wd_r == DIR_W'(NDIR-1)) begin
        step_r <= step_r + REACH_W'(1);
      end
    end
    if (cmd.walk_issue) begin
      ev_d_r  <= wd_r;
      ev_on_r <= won;
      ev_x_r  <= wx[CELL_W-1:0];
      ev_y_r  <= wy[CELL_W-1:0];
    end
  end

  // per direction state
  logic [NDIR-1:0]         drop_r, done_r, stepped_r, drop_nxt, done_nxt, stepped_nxt;
  logic signed [HGT_W-1:0] peak_r [NDIR];
  logic signed [HGT_W-1:0] peak_nxt [NDIR];
  logic [CELL_W-1:0]       ec_r [NDIR];
  logic [CELL_W-1:0]       er_r [NDIR];
  logic [CELL_W-1:0]       ec_nxt [NDIR];
  logic [CELL_W-1:0]       er_nxt [NDIR];
  logic [DIR_W-1:0]        pk_d_r, dix;

  assign dix = cmd.pick ? pk_d_r : ev_d_r;

  always_comb begin
    drop_nxt    = drop_r;
    done_nxt    = done_r;
    stepped_nxt = stepped_r;
    peak_nxt    = peak_r;
    ec_nxt      = ec_r;
    er_nxt      = er_r;
    if (cmd.walk_init) begin
      drop_nxt    = '0;
      done_nxt    = '0;
      stepped_nxt = '0;
      for (int d = 0; d < NDIR; d++) begin
        peak_nxt[d] = HGT_MIN;
      end
    end else if (ev_v_r && !drop_r[dix] && !done_r[dix]) begin
      if (!ev_on_r || (h_rd >= limit_r)) begin
        drop_nxt[dix] = 1'b1;
      end else begin
        if (peak_r[dix] < h_rd) begin
          peak_nxt[dix] = h_rd;
        end
        ec_nxt[dix]      = ev_x_r;
        er_nxt[dix]      = ev_y_r;
        stepped_nxt[dix] = 1'b1;
        if (occ_rd == 1'b0) begin
          done_nxt[dix] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    drop_r    <= drop_nxt;
    done_r    <= done_nxt;
    stepped_r <= stepped_nxt;
    peak_r    <= peak_nxt;
    ec_r      <= ec_nxt;
    er_r      <= er_nxt;
  end

  // least peak over valid directions, lowest index wins ties
  logic                    best_v_r, cand;
  logic signed [HGT_W-1:0] best_peak_r;
  logic [CELL_W-1:0]       best_col_r, best_row_r;

  assign cand = !drop_r[dix] && stepped_r[dix] && (!best_v_r || (peak_r[dix] < best_peak_r));

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      best_v_r <= 1'b0;
      pk_d_r   <= '0;
    end else if (cmd.pick) begin
      pk_d_r <= pk_d_r + DIR_W'(1);
      if (cand) begin
        best_v_r    <= 1'b1;
        best_peak_r <= peak_r[dix];
        best_col_r  <= ec_r[dix];
        best_row_r  <= er_r[dix];
      end
    end
  end

  // result and output register
  logic [CELL_W-1:0]     res_col_r, res_row_r;
  logic                  res_found_r;
  status_t               res_status_r;
  logic                  out_valid_r;
  logic [OUT_CELL_W-1:0] out_col_r, out_row_r;
  logic                  out_found_r;
  status_t               out_status_r;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_INS: begin
          res_col_r    <= on_grid ? c_r[CELL_W-1:0] : '0;
          res_row_r    <= on_grid ? r_r[CELL_W-1:0] : '0;
          res_found_r  <= 1'b0;
          res_status_r <= on_grid ? ST_OK : ST_PT_OFF;
        end
        RES_QOFF: begin
          res_col_r    <= '0;
          res_row_r    <= '0;
          res_found_r  <= 1'b0;
          res_status_r <= ST_Q_OFF;
        end
        RES_QFREE: begin
          res_col_r    <= c_r[CELL_W-1:0];
          res_row_r    <= r_r[CELL_W-1:0];
          res_found_r  <= 1'b1;
          res_status_r <= ST_OK;
        end
        RES_PICK: begin
          res_col_r    <= best_v_r ? best_col_r : c_r[CELL_W-1:0];
          res_row_r    <= best_v_r ? best_row_r : r_r[CELL_W-1:0];
          res_found_r  <= best_v_r;
          res_status_r <= best_v_r ? ST_OK : ST_NO_DIR;
        end
        default: begin
          res_col_r    <= '0;
          res_row_r    <= '0;
          res_found_r  <= 1'b0;
          res_status_r <= ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col_r    <= res_col_r[OUT_CELL_W-1:0];
      out_row_r    <= res_row_r[OUT_CELL_W-1:0];
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cell_col = out_col_r;
  assign out_cell_row = out_row_r;
  assign out_found    = out_found_r;
  assign out_status   = out_status_r;

  always_comb begin
    sts            = '0;
    sts.kind       = kind_r;
    sts.on_grid    = on_grid;
    sts.clr_last   = (clr_r == {ADDR_W{1'b1}});
    sts.sq_empty   = sq_empty_r;
    sts.sq_last    = (sqi_r == sq_c1_r) && (sqj_r == sq_r1_r);
    sts.occ_free   = (occ_rd == 1'b0);
    sts.reach_zero = (reach_r == '0);
    sts.walk_last  = (wd_r == DIR_W'(NDIR-1)) && (step_r == reach_r);
    sts.pick_last  = (pk_d_r == DIR_W'(NDIR-1));
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

// ===== sv/ogfs_checker.sv =====
// Port-level checks for the occupancy grid core, bound to the top level.
module ogfs_checker import ogfs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [OUT_CELL_W-1:0] out_cell_col,
  input logic [OUT_CELL_W-1:0] out_cell_row,
  input logic                  out_found,
  input logic [1:0]            out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_cell_col, out_cell_row, out_found, out_status}))
    else $error("result word changed while stalled");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found with non-ok status");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_PT_OFF || out_status == ST_Q_OFF) |->
      out_cell_col == '0 && out_cell_row == '0 && !out_found)
    else $error("off-grid result carries a cell");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

endmodule

bind occupancy_grid_free_cell_search_core ogfs_checker u_ogfs_checker (.*);
